### rtl/mst_pkg.sv
// Shared types and constants for the minimum segment tree.
package mst_pkg;

    localparam int unsigned VAL_W = 30;
    localparam int unsigned POS_W = 10;

    localparam logic [VAL_W-1:0] EMPTY_VALUE = 30'd1000000000;

    // Item kinds carried on the input tuser.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Field offsets inside the input tdata.
    localparam int unsigned POS_LSB = 0;
    localparam int unsigned VAL_LSB = POS_LSB + POS_W;
    localparam int unsigned LO_LSB  = VAL_LSB + VAL_W;
    localparam int unsigned HI_LSB  = LO_LSB + POS_W;
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned M_DATA_W = 32;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_U_SIB,
        ST_U_PAR,
        ST_Q_LEFT,
        ST_Q_LDATA,
        ST_Q_RIGHT,
        ST_Q_RDATA,
        ST_DONE
    } state_t;

endpackage

### rtl/mst_ram.sv
// Single-port node memory with a registered read port.
module mst_ram #(
    parameter int unsigned DEPTH  = 2048,
    parameter int unsigned ADDR_W = 11
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         addr,
    input  logic [mst_pkg::VAL_W-1:0] wdata,
    output logic [mst_pkg::VAL_W-1:0] rdata
);

    logic [mst_pkg::VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/mst_seq.sv
// Sequencer that walks the tree for updates and queries around one shared min unit.
module mst_seq #(
    parameter int unsigned LEAVES = 1024,
    parameter int unsigned IW     = 11
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_action,
    input  logic [mst_pkg::POS_W-1:0] in_position,
    input  logic [mst_pkg::VAL_W-1:0] in_value,
    input  logic [mst_pkg::POS_W-1:0] in_range_low,
    input  logic [mst_pkg::POS_W-1:0] in_range_high,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic [mst_pkg::VAL_W-1:0] res_data,
    output logic                      mem_we,
    output logic [IW-1:0]             mem_addr,
    output logic [mst_pkg::VAL_W-1:0] mem_wdata,
    input  logic [mst_pkg::VAL_W-1:0] mem_rdata
);

    // Node indexes carry one extra bit so that the exclusive right bound fits.
    localparam int unsigned NW = IW + 1;
    localparam int unsigned CW = (NW > mst_pkg::POS_W) ? NW : mst_pkg::POS_W;
    localparam logic [CW-1:0] LEAF_C  = CW'(LEAVES);
    localparam logic [CW-1:0] LAST_C  = CW'(LEAVES - 1);
    localparam logic [IW-1:0] CLR_END = IW'(2 * LEAVES - 1);
    localparam logic [NW-1:0] ROOT    = NW'(1);

    mst_pkg::state_t state_reg, state_next;
    logic [NW-1:0]             l_reg, l_next;
    logic [NW-1:0]             r_reg, r_next;
    logic [mst_pkg::VAL_W-1:0] acc_reg, acc_next;
    logic [IW-1:0]             clr_reg, clr_next;

    logic [mst_pkg::VAL_W-1:0] min_a, min_b, min_y;
    logic [CW-1:0]             pos_c, lo_c, hi_e, hi_c;
    logic [NW-1:0]             sib, par, r_dec;

    // The one min unit of the block.
    assign min_y = (min_a < min_b) ? min_a : min_b;

    assign pos_c = CW'(in_position);
    assign lo_c  = CW'(in_range_low);
    assign hi_e  = CW'(in_range_high);
    assign hi_c  = (hi_e > LAST_C) ? LAST_C : hi_e;
    assign sib   = l_reg ^ ROOT;
    assign par   = l_reg >> 1;
    assign r_dec = r_reg - ROOT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mst_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
    end

    always_comb begin
        state_next = state_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        acc_next   = acc_reg;
        clr_next   = clr_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = l_reg[IW-1:0];
        mem_wdata  = min_y;
        min_a      = acc_reg;
        min_b      = mem_rdata;
        case (state_reg)
            mst_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = mst_pkg::EMPTY_VALUE;
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == CLR_END) begin
                    state_next = mst_pkg::ST_IDLE;
                end
            end
            mst_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                // Clamping an oversized value is a min against the empty value.
                min_a = in_value;
                min_b = mst_pkg::EMPTY_VALUE;
                if (in_valid) begin
                    if (in_action == mst_pkg::ACT_WRITE) begin
                        if (pos_c < LEAF_C) begin
                            l_next     = NW'(pos_c + LEAF_C);
                            mem_we     = 1'b1;
                            mem_addr   = IW'(pos_c + LEAF_C);
                            acc_next   = min_y;
                            state_next = mst_pkg::ST_U_SIB;
                        end
                    end else begin
                        acc_next = mst_pkg::EMPTY_VALUE;
                        if (lo_c >= LEAF_C || lo_c > hi_c) begin
                            state_next = mst_pkg::ST_DONE;
                        end else begin
                            l_next     = NW'(lo_c + LEAF_C);
                            r_next     = NW'(hi_c + LEAF_C + CW'(1));
                            state_next = mst_pkg::ST_Q_LEFT;
                        end
                    end
                end
            end
            mst_pkg::ST_U_SIB: begin
                mem_addr   = sib[IW-1:0];
                state_next = mst_pkg::ST_U_PAR;
            end
            mst_pkg::ST_U_PAR: begin
                // The parent takes the smaller of the fresh child and its sibling.
                mem_we   = 1'b1;
                mem_addr = par[IW-1:0];
                acc_next = min_y;
                l_next   = par;
                state_next = (par == ROOT) ? mst_pkg::ST_IDLE : mst_pkg::ST_U_SIB;
            end
            mst_pkg::ST_Q_LEFT: begin
                if (l_reg >= r_reg) begin
                    state_next = mst_pkg::ST_DONE;
                end else if (l_reg[0]) begin
                    mem_addr   = l_reg[IW-1:0];
                    l_next     = l_reg + ROOT;
                    state_next = mst_pkg::ST_Q_LDATA;
                end else begin
                    state_next = mst_pkg::ST_Q_RIGHT;
                end
            end
            mst_pkg::ST_Q_LDATA: begin
                acc_next   = min_y;
                state_next = mst_pkg::ST_Q_RIGHT;
            end
            mst_pkg::ST_Q_RIGHT: begin
                if (r_reg[0]) begin
                    mem_addr   = r_dec[IW-1:0];
                    r_next     = r_dec;
                    state_next = mst_pkg::ST_Q_RDATA;
                end else begin
                    l_next     = l_reg >> 1;
                    r_next     = r_reg >> 1;
                    state_next = mst_pkg::ST_Q_LEFT;
                end
            end
            mst_pkg::ST_Q_RDATA: begin
                acc_next   = min_y;
                l_next     = l_reg >> 1;
                r_next     = r_reg >> 1;
                state_next = mst_pkg::ST_Q_LEFT;
            end
            mst_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = mst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mst_pkg::ST_IDLE;
            end
        endcase
    end

    assign res_data = acc_reg;

    a_wdata_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> mem_wdata <= mst_pkg::EMPTY_VALUE)
        else $error("node write above the empty value");

    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mst_pkg::ST_Q_LEFT) |-> l_reg <= r_reg)
        else $error("query bounds crossed");

    a_no_write_in_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mst_pkg::ST_Q_LEFT || state_reg == mst_pkg::ST_Q_LDATA ||
         state_reg == mst_pkg::ST_Q_RIGHT || state_reg == mst_pkg::ST_Q_RDATA ||
         state_reg == mst_pkg::ST_DONE) |-> !mem_we)
        else $error("tree written during a query");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid && $stable(res_data))
        else $error("pending result changed");

endmodule

### rtl/min_segment_tree.sv
// Top level of the minimum segment tree with its stream ports and result register.

// A store of LEAVES values kept as a binary minimum tree in one single-port memory of
// 2*LEAVES nodes. An update beat (tuser 0) with a position below LEAVES writes a leaf
// and recomputes its ancestors, with a sibling read and a parent write per level; other
// update beats are dropped. A query beat (tuser 1) returns the minimum over an inclusive
// leaf range, reading nodes on the same port, then checking the final bound and handing
// off the result; a low bound out of range or above the high one gives the empty value. After
// reset a clearing pass writes the empty value
// 1000000000 into all 2*LEAVES nodes, one a cycle, and no beat is taken until it is done.
// The block takes one item at a time; a finished minimum waits in the output register
// while the next item is accepted.
module min_segment_tree #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // position[9:0], value[39:10], range_low[49:40], range_high[59:50], zeros above
    input  logic [mst_pkg::S_DATA_W-1:0]  s_tdata,
    // action[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // minimum[29:0], zeros above
    output logic [mst_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int unsigned IW = $clog2(2 * LEAVES);

    logic                      res_valid, res_ready;
    logic [mst_pkg::VAL_W-1:0] res_data;
    logic                      mem_we;
    logic [IW-1:0]             mem_addr;
    logic [mst_pkg::VAL_W-1:0] mem_wdata, mem_rdata;
    logic                      m_valid_reg, m_valid_next;
    logic [mst_pkg::VAL_W-1:0] m_data_reg, m_data_next;

    mst_seq #(
        .LEAVES (LEAVES),
        .IW     (IW)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_action     (s_tuser),
        .in_position   (s_tdata[mst_pkg::POS_LSB +: mst_pkg::POS_W]),
        .in_value      (s_tdata[mst_pkg::VAL_LSB +: mst_pkg::VAL_W]),
        .in_range_low  (s_tdata[mst_pkg::LO_LSB +: mst_pkg::POS_W]),
        .in_range_high (s_tdata[mst_pkg::HI_LSB +: mst_pkg::POS_W]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_data      (res_data),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata)
    );

    mst_ram #(
        .DEPTH  (2 * LEAVES),
        .ADDR_W (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_data_next = res_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mst_pkg::M_DATA_W - mst_pkg::VAL_W){1'b0}}, m_data_reg};

endmodule
